FILE: rtl/u8sd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// u8sd_pkg
// Shared types and codes for the UTF-8 stream decoder.
// ---------------------------------------------------------------------------
package u8sd_pkg;

    // Byte classes, as seen when no sequence is in progress.
    localparam logic [2:0] KIND_NUL     = 3'd0;
    localparam logic [2:0] KIND_ASCII   = 3'd1;
    localparam logic [2:0] KIND_LEAD2   = 3'd2;
    localparam logic [2:0] KIND_LEAD3   = 3'd3;
    localparam logic [2:0] KIND_LEAD4   = 3'd4;
    localparam logic [2:0] KIND_INVALID = 3'd5;

    // Result status codes.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NULL       = 2'd1;
    localparam logic [1:0] ST_INVALID    = 2'd2;
    localparam logic [1:0] ST_INCOMPLETE = 2'd3;

    localparam int CP_W    = 21;
    localparam int CNT_W   = 3;
    localparam int ST_W    = 2;
    localparam int QDEPTH  = 2;

    // One classified byte, as it travels from the front end to the back end.
    typedef struct packed {
        logic [2:0] kind;
        logic [4:0] lead_bits;  // lead payload, already masked for its length
        logic [5:0] low6;       // payload if the byte follows a lead
        logic [6:0] ascii;      // value if the byte is a single-byte character
        logic       last;       // last byte of the buffer
    } t_cls;

endpackage
`default_nettype wire

FILE: rtl/u8sd_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// u8sd_front
// Accepts input bytes and classifies each one by its lead pattern.
// ---------------------------------------------------------------------------
module u8sd_front (
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_last,
    output u8sd_pkg::t_cls     o_cls,
    output logic               o_push
);

    // Classify the byte by its high bits and mask its payload.
    always_comb begin
        o_cls.low6      = i_byte[5:0];
        o_cls.ascii     = i_byte[6:0];
        o_cls.last      = i_last;
        o_cls.lead_bits = 5'd0;
        if (i_byte == 8'h00) begin
            o_cls.kind = u8sd_pkg::KIND_NUL;
        end else if (i_byte[7] == 1'b0) begin
            o_cls.kind = u8sd_pkg::KIND_ASCII;
        end else if (i_byte[7:5] == 3'b110) begin
            o_cls.kind      = u8sd_pkg::KIND_LEAD2;
            o_cls.lead_bits = i_byte[4:0];
        end else if (i_byte[7:4] == 4'b1110) begin
            o_cls.kind      = u8sd_pkg::KIND_LEAD3;
            o_cls.lead_bits = {1'b0, i_byte[3:0]};
        end else if (i_byte[7:3] == 5'b11110) begin
            o_cls.kind      = u8sd_pkg::KIND_LEAD4;
            o_cls.lead_bits = {2'b00, i_byte[2:0]};
        end else begin
            o_cls.kind = u8sd_pkg::KIND_INVALID;
        end
    end

    // A transaction on the input side pushes one entry.
    assign o_push = i_valid;

endmodule
`default_nettype wire

FILE: rtl/u8sd_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// u8sd_queue
// Two-entry queue of classified bytes between the front and back ends.
// ---------------------------------------------------------------------------
module u8sd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  u8sd_pkg::t_cls     i_data,
    output logic               o_ready,
    output logic               o_valid,
    output u8sd_pkg::t_cls     o_data,
    input  wire logic          i_pop
);

    u8sd_pkg::t_cls r_mem [u8sd_pkg::QDEPTH];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_count;
    logic           n_wr;
    logic           n_rd;
    logic [1:0]     n_count;
    logic           w_do_push;
    logic           w_do_pop;

    assign o_ready   = (r_count != 2'(u8sd_pkg::QDEPTH));
    assign o_valid   = (r_count != 2'd0);
    assign o_data    = r_mem[r_rd];
    assign w_do_push = i_push && o_ready;
    assign w_do_pop  = i_pop && o_valid;

    // Pointer and fill count update.
    always_comb begin
        n_wr    = w_do_push ? ~r_wr : r_wr;
        n_rd    = w_do_pop ? ~r_rd : r_rd;
        n_count = r_count + 2'(w_do_push) - 2'(w_do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/u8sd_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// u8sd_back
// Runs the sequence state and registers one result per finished character or error.
// ---------------------------------------------------------------------------
module u8sd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  u8sd_pkg::t_cls     i_cls,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [u8sd_pkg::CP_W-1:0]  o_code_point,
    output logic [u8sd_pkg::CNT_W-1:0] o_byte_count,
    output logic [u8sd_pkg::ST_W-1:0]  o_status
);

    logic [1:0]                  r_remain;
    logic [2:0]                  r_len;
    logic [u8sd_pkg::CP_W-1:0]   r_part;
    logic                        r_out_valid;
    logic [u8sd_pkg::CP_W-1:0]   r_cp;
    logic [u8sd_pkg::CNT_W-1:0]  r_cnt;
    logic [u8sd_pkg::ST_W-1:0]   r_st;

    logic [1:0]                  n_remain;
    logic [2:0]                  n_len;
    logic [u8sd_pkg::CP_W-1:0]   n_part;
    logic                        w_emit;
    logic [u8sd_pkg::CP_W-1:0]   w_cp;
    logic [u8sd_pkg::CNT_W-1:0]  w_cnt;
    logic [u8sd_pkg::ST_W-1:0]   w_st;
    logic [u8sd_pkg::CP_W-1:0]   w_shift;

    // Take an entry whenever the output register is free or being drained.
    assign o_pop = i_valid && (!r_out_valid || i_ready);

    assign w_shift = {r_part[u8sd_pkg::CP_W-7:0], i_cls.low6};

    // Next state and result for the entry at the head of the queue.
    always_comb begin
        n_remain = r_remain;
        n_len    = r_len;
        n_part   = r_part;
        w_emit   = 1'b0;
        w_cp     = '0;
        w_cnt    = '0;
        w_st     = u8sd_pkg::ST_OK;
        if (r_remain == 2'd0) begin
            unique case (i_cls.kind)
                u8sd_pkg::KIND_NUL: begin
                    w_emit = 1'b1;
                    w_st   = u8sd_pkg::ST_NULL;
                end
                u8sd_pkg::KIND_ASCII: begin
                    w_emit = 1'b1;
                    w_cp   = {14'd0, i_cls.ascii};
                    w_cnt  = 3'd1;
                end
                u8sd_pkg::KIND_LEAD2: begin
                    n_remain = 2'd1;
                    n_len    = 3'd2;
                end
                u8sd_pkg::KIND_LEAD3: begin
                    n_remain = 2'd2;
                    n_len    = 3'd3;
                end
                u8sd_pkg::KIND_LEAD4: begin
                    n_remain = 2'd3;
                    n_len    = 3'd4;
                end
                default: begin
                    w_emit = 1'b1;
                    w_st   = u8sd_pkg::ST_INVALID;
                end
            endcase
            if (i_cls.kind == u8sd_pkg::KIND_LEAD2 || i_cls.kind == u8sd_pkg::KIND_LEAD3 ||
                i_cls.kind == u8sd_pkg::KIND_LEAD4) begin
                n_part = {16'd0, i_cls.lead_bits};
                if (i_cls.last) begin
                    // A buffer that ends right after a lead byte.
                    n_remain = 2'd0;
                    n_len    = 3'd0;
                    n_part   = '0;
                    w_emit   = 1'b1;
                    w_st     = u8sd_pkg::ST_INCOMPLETE;
                end
            end
        end else begin
            n_remain = r_remain - 2'd1;
            n_part   = w_shift;
            if (r_remain == 2'd1) begin
                // The last following byte completes the character.
                w_emit   = 1'b1;
                w_cp     = w_shift;
                w_cnt    = r_len;
                n_len    = 3'd0;
                n_part   = '0;
            end else if (i_cls.last) begin
                w_emit   = 1'b1;
                w_st     = u8sd_pkg::ST_INCOMPLETE;
                n_remain = 2'd0;
                n_len    = 3'd0;
                n_part   = '0;
            end
        end
    end

    // Sequence state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remain <= 2'd0;
            r_len    <= 3'd0;
            r_part   <= '0;
        end else if (o_pop) begin
            r_remain <= n_remain;
            r_len    <= n_len;
            r_part   <= n_part;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= w_emit;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            r_cp  <= w_cp;
            r_cnt <= w_cnt;
            r_st  <= w_st;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_code_point = r_cp;
    assign o_byte_count = r_cnt;
    assign o_status     = r_st;

endmodule
`default_nettype wire

FILE: rtl/utf8_stream_decoder_top.sv
`default_nettype none
// A finishing byte is queued, then decoded from the queue head into the output register.
// Throughput: one byte per cycle while the output register is free or being drained.
// A two-entry queue parts input and output; while a result waits, input takes bytes
// until both queue entries are full and then stalls.
// Reset: synchronous, active low; clears the queue, the sequence state and the output valid flag.
// ---------------------------------------------------------------------------
// utf8_stream_decoder_top
// Streaming UTF-8 decoder: one byte in per transaction, one code point or
// status out per finished character or error.
// ---------------------------------------------------------------------------
module utf8_stream_decoder_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic        i_s_axis_tlast,   // buffer_end
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata    // [20:0] code_point, [23:21] byte_count,
                                               // [25:24] status, [31:26] zero
);

    u8sd_pkg::t_cls w_front_cls;
    u8sd_pkg::t_cls w_head_cls;
    logic           w_push;
    logic           w_q_valid;
    logic           w_pop;
    logic [u8sd_pkg::CP_W-1:0]  w_cp;
    logic [u8sd_pkg::CNT_W-1:0] w_cnt;
    logic [u8sd_pkg::ST_W-1:0]  w_st;

    // Front end: classify incoming bytes.
    u8sd_front u_front (
        .i_valid (i_s_axis_tvalid),
        .i_byte  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .o_cls   (w_front_cls),
        .o_push  (w_push)
    );

    // Queue between the two ends.
    u8sd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_cls),
        .o_ready (o_s_axis_tready),
        .o_valid (w_q_valid),
        .o_data  (w_head_cls),
        .i_pop   (w_pop)
    );

    // Back end: sequence state and result register.
    u8sd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_q_valid),
        .i_cls        (w_head_cls),
        .o_pop        (w_pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_code_point (w_cp),
        .o_byte_count (w_cnt),
        .o_status     (w_st)
    );

    assign o_m_axis_tdata = {6'd0, w_st, w_cnt, w_cp};

endmodule
`default_nettype wire
